>>> rtl/core/pftt_pkg.sv
// ----------------------------------------------------------------------------
// pftt_pkg
// Shared types and constants of the process flow tracking table.
// ----------------------------------------------------------------------------
package pftt_pkg;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam int unsigned PID_W   = 22;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned COUNT_W = 32;

  localparam int unsigned IN_DATA_W  = 160;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 232;
  localparam int unsigned OUT_USER_W = 3;

  typedef enum logic [1:0] {
    CMD_RECORD = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_UPDATED   = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_REMOVED   = 3'd5
  } status_e;

  // operation walking down the row of entries
  typedef struct packed {
    logic                 valid;
    cmd_e                 cmd;
    logic [PID_W-1:0]     pid;
    logic [PID_W-1:0]     parent;
    logic [ADDR_W-1:0]    addr;
    logic [PORT_W-1:0]    port;
    logic [TIME_W-1:0]    tnow;
    logic                 done;
    logic                 free_hit;
    logic [IDX_W-1:0]     free_idx;
    status_e              status;
    logic [PID_W-1:0]     f_parent;
    logic [ADDR_W-1:0]    f_addr;
    logic [PORT_W-1:0]    f_port;
    logic [TIME_W-1:0]    f_first;
    logic [TIME_W-1:0]    f_last;
    logic [COUNT_W-1:0]   f_count;
  } tok_t;

  // new-entry write broadcast from the tail to all entries
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [PID_W-1:0]  pid;
    logic [PID_W-1:0]  parent;
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
    logic [TIME_W-1:0] tnow;
  } ins_t;

endpackage

>>> rtl/core/pftt_cell.sv
// ----------------------------------------------------------------------------
// pftt_cell
// One table entry; applies the passing operation and hands it to the next.
// ----------------------------------------------------------------------------
module pftt_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic [pftt_pkg::IDX_W-1:0]    idx_i,
  input  pftt_pkg::tok_t                tok_i,
  input  pftt_pkg::ins_t                ins_i,
  output pftt_pkg::tok_t                tok_o
);

  logic                           valid_q, valid_d;
  logic [pftt_pkg::PID_W-1:0]     proc_q, proc_d;
  logic [pftt_pkg::PID_W-1:0]     parent_q, parent_d;
  logic [pftt_pkg::ADDR_W-1:0]    addr_q, addr_d;
  logic [pftt_pkg::PORT_W-1:0]    port_q, port_d;
  logic [pftt_pkg::TIME_W-1:0]    first_q, first_d;
  logic [pftt_pkg::TIME_W-1:0]    last_q, last_d;
  logic [pftt_pkg::COUNT_W-1:0]   count_q, count_d;
  pftt_pkg::tok_t                 tok_q, tok_d;
  logic                           hit;

  assign hit = tok_i.valid && valid_q && !tok_i.done && (proc_q == tok_i.pid);

  always_comb begin
    valid_d  = valid_q;
    proc_d   = proc_q;
    parent_d = parent_q;
    addr_d   = addr_q;
    port_d   = port_q;
    first_d  = first_q;
    last_d   = last_q;
    count_d  = count_q;
    tok_d    = tok_i;
    if (hit) begin
      unique case (tok_i.cmd)
        pftt_pkg::CMD_RECORD: begin
          addr_d       = tok_i.addr;
          port_d       = tok_i.port;
          last_d       = tok_i.tnow;
          count_d      = (count_q != '1) ? count_q + pftt_pkg::COUNT_W'(1) : count_q;
          tok_d.done   = 1'b1;
          tok_d.status = pftt_pkg::ST_UPDATED;
        end
        pftt_pkg::CMD_LOOKUP: begin
          tok_d.done     = 1'b1;
          tok_d.status   = pftt_pkg::ST_FOUND;
          tok_d.f_parent = parent_q;
          tok_d.f_addr   = addr_q;
          tok_d.f_port   = port_q;
          tok_d.f_first  = first_q;
          tok_d.f_last   = last_q;
          tok_d.f_count  = count_q;
        end
        pftt_pkg::CMD_REMOVE: begin
          valid_d      = 1'b0;
          tok_d.done   = 1'b1;
          tok_d.status = pftt_pkg::ST_REMOVED;
        end
        default: begin
        end
      endcase
    end
    if (tok_i.valid && !valid_q && !tok_i.free_hit) begin
      tok_d.free_hit = 1'b1;
      tok_d.free_idx = idx_i;
    end
    if (ins_i.en && (ins_i.idx == idx_i)) begin
      valid_d  = 1'b1;
      proc_d   = ins_i.pid;
      parent_d = ins_i.parent;
      addr_d   = ins_i.addr;
      port_d   = ins_i.port;
      first_d  = ins_i.tnow;
      last_d   = ins_i.tnow;
      count_d  = pftt_pkg::COUNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else if (adv_i) begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      proc_q   <= proc_d;
      parent_q <= parent_d;
      addr_q   <= addr_d;
      port_q   <= port_d;
      first_q  <= first_d;
      last_q   <= last_d;
      count_q  <= count_d;
    end
  end

  assign tok_o = tok_q;

endmodule

>>> rtl/core/pftt_tail.sv
// ----------------------------------------------------------------------------
// pftt_tail
// End of the row: final status, new-entry write and output register.
// ----------------------------------------------------------------------------
module pftt_tail (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pftt_pkg::tok_t                      tok_i,
  input  logic                                m_axis_tready,
  output logic                                adv_o,
  output logic                                fire_o,
  output pftt_pkg::ins_t                      ins_o,
  output logic                                m_axis_tvalid,
  output logic [pftt_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic [pftt_pkg::OUT_USER_W-1:0]     m_axis_tuser
);

  logic                                 out_valid_q;
  logic [pftt_pkg::OUT_DATA_W-1:0]      data_q, data_d;
  pftt_pkg::status_e                    status_q, status_d;
  logic                                 fire;

  assign fire   = tok_i.valid && (!out_valid_q || m_axis_tready);
  assign adv_o  = !(tok_i.valid && out_valid_q && !m_axis_tready);
  assign fire_o = fire;

  always_comb begin
    ins_o.en     = fire && !tok_i.done && (tok_i.cmd == pftt_pkg::CMD_RECORD) &&
                   tok_i.free_hit;
    ins_o.idx    = tok_i.free_idx;
    ins_o.pid    = tok_i.pid;
    ins_o.parent = tok_i.parent;
    ins_o.addr   = tok_i.addr;
    ins_o.port   = tok_i.port;
    ins_o.tnow   = tok_i.tnow;

    priority if (tok_i.done) begin
      status_d = tok_i.status;
    end else if (tok_i.cmd == pftt_pkg::CMD_RECORD) begin
      status_d = tok_i.free_hit ? pftt_pkg::ST_INSERTED : pftt_pkg::ST_FULL;
    end else begin
      status_d = pftt_pkg::ST_NOT_FOUND;
    end

    data_d = {2'b00, tok_i.f_count, tok_i.f_last, tok_i.f_first,
              tok_i.f_port, tok_i.f_addr, tok_i.f_parent};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      data_q   <= data_d;
      status_q <= status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = status_q;

endmodule

>>> rtl/core/process_flow_tracking_table.sv
// ----------------------------------------------------------------------------
// process_flow_tracking_table
// Per-process network record table keyed by process id.
// ----------------------------------------------------------------------------
// Usage: one operation per slave transfer (tuser selects record, lookup or
// remove), one result per master transfer (tuser carries the status).
// The table is a row of TABLE_ENTRIES cells. An accepted operation moves one
// cell per cycle; the first cell holding its key acts on it, so the lowest
// index wins. A record with no match writes the lowest free cell when it
// leaves the row.
// The operation passes through the register of every cell, then through the
// output register. One operation is in the row at a time: a new one is
// accepted only after the current one has left the row.
// A finished result waits in the output register; the next operation may be
// accepted meanwhile. If the result is still held when the following one
// reaches the end of the row, the row stalls until the receiver takes it.
// Reset clears every entry's valid mark and empties the row and the output.
// ----------------------------------------------------------------------------
module process_flow_tracking_table (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // process_id, parent_id, dest_address, dest_port, event_time, zero pad
  input  logic [pftt_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // cmd
  input  logic [pftt_pkg::IN_USER_W-1:0]      s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // found_parent, found_address, found_port, found_first_time,
  // found_last_time, found_count, zero pad
  output logic [pftt_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // status
  output logic [pftt_pkg::OUT_USER_W-1:0]     m_axis_tuser
);

  pftt_pkg::tok_t tok_w [pftt_pkg::TABLE_ENTRIES+1];
  pftt_pkg::ins_t ins;
  logic           adv;
  logic           fire;
  logic           busy_q;
  logic           accept;

  assign s_axis_tready = !busy_q;
  assign accept        = s_axis_tvalid && !busy_q;

  always_comb begin
    tok_w[0]          = '0;
    tok_w[0].valid    = accept;
    tok_w[0].cmd      = pftt_pkg::cmd_e'(s_axis_tuser[1:0]);
    tok_w[0].pid      = s_axis_tdata[21:0];
    tok_w[0].parent   = s_axis_tdata[43:22];
    tok_w[0].addr     = s_axis_tdata[75:44];
    tok_w[0].port     = s_axis_tdata[91:76];
    tok_w[0].tnow     = s_axis_tdata[155:92];
    tok_w[0].status   = pftt_pkg::ST_NOT_FOUND;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
    end else if (fire) begin
      busy_q <= 1'b0;
    end
  end

  for (genvar i = 0; i < pftt_pkg::TABLE_ENTRIES; i++) begin : g_cell
    pftt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .idx_i  (pftt_pkg::IDX_W'(i)),
      .tok_i  (tok_w[i]),
      .ins_i  (ins),
      .tok_o  (tok_w[i+1])
    );
  end

  pftt_tail u_tail (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tok_i         (tok_w[pftt_pkg::TABLE_ENTRIES]),
    .m_axis_tready (m_axis_tready),
    .adv_o         (adv),
    .fire_o        (fire),
    .ins_o         (ins),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
